/* rtl/core/aps_pkg.sv */
// Shared types, constants and helper functions of the ATA PIO sector sequencer.
`timescale 1ns / 1ps
package aps_pkg;

	// Default sector size in 16-bit words.
	localparam int WORDS_PER_SECTOR_DEF = 256;

	// Depth of the job queue between front and back.
	localparam int QUEUE_DEPTH = 4;
	localparam int QUEUE_IDX_W = $clog2(QUEUE_DEPTH);
	localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

	// Input item codes.
	typedef enum logic [1:0] {
		MODE_READ_REQ  = 2'd0,
		MODE_WRITE_REQ = 2'd1,
		MODE_STATUS    = 2'd2,
		MODE_DATA      = 2'd3
	} aps_mode_t;

	// Result item codes.
	typedef enum logic [1:0] {
		KIND_BYTE_WR   = 2'd0,
		KIND_STATUS_RD = 2'd1,
		KIND_WORD_WR   = 2'd2,
		KIND_READ_DATA = 2'd3
	} aps_kind_t;

	// Task-file register offsets.
	localparam logic [15:0] REG_DATA    = 16'd0;
	localparam logic [15:0] REG_ERROR   = 16'd1;
	localparam logic [15:0] REG_COUNT   = 16'd2;
	localparam logic [15:0] REG_LBA_LO  = 16'd3;
	localparam logic [15:0] REG_LBA_MID = 16'd4;
	localparam logic [15:0] REG_LBA_HI  = 16'd5;
	localparam logic [15:0] REG_HEAD    = 16'd6;
	localparam logic [15:0] REG_CMD     = 16'd7;

	// Command and mask constants.
	localparam logic [7:0] CMD_READ28   = 8'h20;
	localparam logic [7:0] CMD_READ48   = 8'h24;
	localparam logic [7:0] CMD_WRITE28  = 8'h30;
	localparam logic [7:0] CMD_WRITE48  = 8'h34;
	localparam logic [7:0] HEAD_LBA28   = 8'hE0;
	localparam logic [7:0] HEAD_LBA48   = 8'h40;
	localparam logic [7:0] FILL_CHAR    = 8'h2E;
	localparam int         DRQ_BIT      = 3;

	// Results per request: task-file writes, command byte, status read.
	localparam int         STEP_W       = 4;
	localparam logic [STEP_W-1:0] LAST_STEP48 = STEP_W'(12);
	localparam logic [STEP_W-1:0] LAST_STEP28 = STEP_W'(7);

	// One unit of work handed from the front to the back.
	typedef struct packed {
		logic        is_req;
		logic        wr;
		logic        l48;
		logic        drv;
		logic [15:0] base;
		logic [47:0] lba;
		aps_kind_t   kind;
		logic [15:0] value;
		logic        last;
	} aps_job_t;

	// One result item.
	typedef struct packed {
		aps_kind_t   kind;
		logic [15:0] port;
		logic [15:0] value;
		logic        last;
	} aps_result_t;

	// Replace every zero byte of a read word by the fill character.
	function automatic logic [15:0] dot_fill(input logic [15:0] w);
		logic [7:0] lo;
		logic [7:0] hi;
		lo = (w[7:0] == 8'd0) ? FILL_CHAR : w[7:0];
		hi = (w[15:8] == 8'd0) ? FILL_CHAR : w[15:8];
		return {hi, lo};
	endfunction

	// Result of one step of a request sequence.
	function automatic aps_result_t req_step(input aps_job_t j, input logic [STEP_W-1:0] s);
		aps_result_t r;
		logic [15:0] off;
		logic [7:0]  val;
		logic [7:0]  cmd;
		if (j.l48) begin
			cmd = j.wr ? CMD_WRITE48 : CMD_READ48;
		end else begin
			cmd = j.wr ? CMD_WRITE28 : CMD_READ28;
		end
		off = REG_CMD;
		val = 8'd0;
		r.kind = KIND_BYTE_WR;
		if (j.l48) begin
			unique case (s)
				4'd0:    begin off = REG_ERROR;   val = 8'd0;         end
				4'd1:    begin off = REG_ERROR;   val = 8'd0;         end
				4'd2:    begin off = REG_COUNT;   val = 8'd0;         end
				4'd3:    begin off = REG_COUNT;   val = 8'd1;         end
				4'd4:    begin off = REG_LBA_LO;  val = j.lba[31:24]; end
				4'd5:    begin off = REG_LBA_LO;  val = j.lba[7:0];   end
				4'd6:    begin off = REG_LBA_MID; val = j.lba[39:32]; end
				4'd7:    begin off = REG_LBA_MID; val = j.lba[15:8];  end
				4'd8:    begin off = REG_LBA_HI;  val = j.lba[47:40]; end
				4'd9:    begin off = REG_LBA_HI;  val = j.lba[23:16]; end
				4'd10:   begin off = REG_HEAD;    val = HEAD_LBA48 | {3'd0, j.drv, 4'd0}; end
				4'd11:   begin off = REG_CMD;     val = cmd;          end
				default: begin off = REG_CMD;     val = 8'd0; r.kind = KIND_STATUS_RD; end
			endcase
		end else begin
			unique case (s)
				4'd0:    begin off = REG_ERROR;   val = 8'd0;         end
				4'd1:    begin off = REG_COUNT;   val = 8'd1;         end
				4'd2:    begin off = REG_LBA_LO;  val = j.lba[7:0];   end
				4'd3:    begin off = REG_LBA_MID; val = j.lba[15:8];  end
				4'd4:    begin off = REG_LBA_HI;  val = j.lba[23:16]; end
				4'd5:    begin
					off = REG_HEAD;
					val = HEAD_LBA28 | {3'd0, j.drv, j.lba[27:24]};
				end
				4'd6:    begin off = REG_CMD;     val = cmd;          end
				default: begin off = REG_CMD;     val = 8'd0; r.kind = KIND_STATUS_RD; end
			endcase
		end
		r.port  = j.base + off;
		r.value = {8'd0, val};
		r.last  = 1'b0;
		return r;
	endfunction

endpackage

/* rtl/core/aps_if.sv */
// Handshake channels of the ATA PIO sector sequencer: request items and result items.
`timescale 1ns / 1ps
interface aps_in_if;
	logic        valid;
	logic        ready;
	logic [1:0]  mode;
	logic        use_lba48;
	logic        drive;
	logic [15:0] bus_base;
	logic [47:0] lba;
	logic [7:0]  status_byte;
	logic [15:0] data_word;

	modport source (output valid, mode, use_lba48, drive, bus_base, lba, status_byte,
		data_word, input ready);
	modport sink (input valid, mode, use_lba48, drive, bus_base, lba, status_byte,
		data_word, output ready);
endinterface

interface aps_out_if;
	logic        valid;
	logic        ready;
	logic [1:0]  access_kind;
	logic [15:0] port_address;
	logic [15:0] access_value;
	logic        last;

	modport source (output valid, access_kind, port_address, access_value, last,
		input ready);
	modport sink (input valid, access_kind, port_address, access_value, last,
		output ready);
endinterface

/* rtl/core/aps_front.sv */
// Front part: accepts items, tracks the transfer phase and queues the work they cause.
`timescale 1ns / 1ps
module aps_front #(
	parameter int WORDS_PER_SECTOR = aps_pkg::WORDS_PER_SECTOR_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	aps_in_if.sink           cmd,
	input  logic             q_full,
	output logic             push,
	output aps_pkg::aps_job_t push_job
);
	import aps_pkg::*;

	localparam int WC_W = (WORDS_PER_SECTOR > 1) ? $clog2(WORDS_PER_SECTOR) : 1;
	localparam logic [WC_W-1:0] WC_LAST = WC_W'(WORDS_PER_SECTOR - 1);

	typedef enum logic [4:0] {
		PH_IDLE  = 5'b00001,
		PH_RWAIT = 5'b00010,
		PH_WWAIT = 5'b00100,
		PH_RDATA = 5'b01000,
		PH_WDATA = 5'b10000
	} phase_t;

	phase_t        phase_q, phase_d;
	logic [WC_W-1:0] word_count_q, word_count_d;
	logic [15:0]   saved_base_q, saved_base_d;
	logic          accept;
	logic          fin;
	aps_mode_t     mode;

	assign cmd.ready = !q_full;
	assign accept    = cmd.valid && cmd.ready;
	assign mode      = aps_mode_t'(cmd.mode);
	assign fin       = (word_count_q == WC_LAST);

	// Classify the item against the current phase.
	always_comb begin
		phase_d      = phase_q;
		word_count_d = word_count_q;
		saved_base_d = saved_base_q;
		push         = 1'b0;
		push_job       = '0;
		push_job.is_req = 1'b0;
		push_job.wr    = (mode == MODE_WRITE_REQ);
		push_job.l48   = cmd.use_lba48;
		push_job.drv   = cmd.drive;
		push_job.lba   = cmd.lba;
		push_job.base  = cmd.bus_base;
		push_job.kind  = KIND_STATUS_RD;
		push_job.value = 16'd0;
		push_job.last  = 1'b0;
		if (accept) begin
			unique case (mode)
				MODE_READ_REQ, MODE_WRITE_REQ: begin
					if (phase_q == PH_IDLE) begin
						push            = 1'b1;
						push_job.is_req = 1'b1;
						saved_base_d    = cmd.bus_base;
						word_count_d    = '0;
						phase_d = (mode == MODE_READ_REQ) ? PH_RWAIT : PH_WWAIT;
					end
				end
				MODE_STATUS: begin
					if (phase_q == PH_RWAIT || phase_q == PH_WWAIT) begin
						if (cmd.status_byte[DRQ_BIT]) begin
							phase_d      = (phase_q == PH_RWAIT) ? PH_RDATA : PH_WDATA;
							word_count_d = '0;
						end else begin
							push          = 1'b1;
							push_job.kind = KIND_STATUS_RD;
							push_job.base = saved_base_q + REG_CMD;
						end
					end
				end
				MODE_DATA: begin
					if (phase_q == PH_RDATA || phase_q == PH_WDATA) begin
						push          = 1'b1;
						push_job.base = saved_base_q + REG_DATA;
						push_job.last = fin;
						if (phase_q == PH_RDATA) begin
							push_job.kind  = KIND_READ_DATA;
							push_job.value = dot_fill(cmd.data_word);
						end else begin
							push_job.kind  = KIND_WORD_WR;
							push_job.value = cmd.data_word;
						end
						if (fin) begin
							phase_d      = PH_IDLE;
							word_count_d = '0;
						end else begin
							word_count_d = word_count_q + WC_W'(1);
						end
					end
				end
				default: begin
				end
			endcase
		end
	end

	// Phase, word count and channel base.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_IDLE;
			word_count_q <= '0;
			saved_base_q <= '0;
		end else begin
			phase_q      <= phase_d;
			word_count_q <= word_count_d;
			saved_base_q <= saved_base_d;
		end
	end

endmodule

/* rtl/core/aps_queue.sv */
// Short job queue between the front and the back.
`timescale 1ns / 1ps
module aps_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  aps_pkg::aps_job_t push_job,
	output logic              full,
	input  logic              pop,
	output logic              head_valid,
	output aps_pkg::aps_job_t head_job
);
	import aps_pkg::*;

	aps_job_t                entries_q [QUEUE_DEPTH];
	logic [QUEUE_IDX_W-1:0]  wr_ptr_q;
	logic [QUEUE_IDX_W-1:0]  rd_ptr_q;
	logic [QUEUE_CNT_W-1:0]  count_q;
	logic                    do_push;
	logic                    do_pop;

	assign full       = (count_q == QUEUE_CNT_W'(QUEUE_DEPTH));
	assign head_valid = (count_q != '0);
	assign head_job   = entries_q[rd_ptr_q];
	assign do_push    = push && !full;
	assign do_pop     = pop && head_valid;

	// Entry storage.
	always_ff @(posedge clk) begin
		if (do_push) begin
			entries_q[wr_ptr_q] <= push_job;
		end
	end

	// Pointers and fill level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + QUEUE_IDX_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + QUEUE_IDX_W'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + QUEUE_CNT_W'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - QUEUE_CNT_W'(1);
			end
		end
	end

endmodule

/* rtl/core/aps_back.sv */
// Back part: expands queued jobs into result items and holds them in the output register.
`timescale 1ns / 1ps
module aps_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              head_valid,
	input  aps_pkg::aps_job_t head_job,
	output logic              pop,
	aps_out_if.source         rsp
);
	import aps_pkg::*;

	logic [STEP_W-1:0] step_q;
	logic              out_valid_q;
	aps_result_t       out_q;
	aps_result_t       next_res;
	logic              load;
	logic              job_done;

	// Result for the current step of the head job.
	always_comb begin
		if (head_job.is_req) begin
			next_res = req_step(head_job, step_q);
			job_done = head_job.l48 ? (step_q == LAST_STEP48) : (step_q == LAST_STEP28);
		end else begin
			next_res.kind  = head_job.kind;
			next_res.port  = head_job.base;
			next_res.value = head_job.value;
			next_res.last  = head_job.last;
			job_done       = 1'b1;
		end
	end

	assign load = head_valid && (!out_valid_q || rsp.ready);
	assign pop  = load && job_done;

	// Step counter and output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				step_q <= job_done ? '0 : step_q + STEP_W'(1);
			end
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Output payload register.
	always_ff @(posedge clk) begin
		if (load) begin
			out_q <= next_res;
		end
	end

	assign rsp.valid        = out_valid_q;
	assign rsp.access_kind  = out_q.kind;
	assign rsp.port_address = out_q.port;
	assign rsp.access_value = out_q.value;
	assign rsp.last         = out_q.last;

endmodule

/* rtl/core/ata_pio_sector_sequencer_core.sv */
// Top level of the ATA PIO sector sequencer: front, job queue and back.
// The first result of an item passes through the job queue and then the output register.
// Throughput: status and data items are taken one per cycle while the job queue has room, each giving at
// most one result; results leave one per cycle while rsp.ready is high. A read or write request expands in
// the back into 8 (LBA28) or 13 (LBA48) results. Input is taken while the four-entry job queue has room.
// Reset is asynchronous: phase returns to idle, counts and queue empty, no result valid.
`timescale 1ns / 1ps
module ata_pio_sector_sequencer_core #(
	parameter int WORDS_PER_SECTOR = aps_pkg::WORDS_PER_SECTOR_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	aps_in_if.sink    cmd,
	aps_out_if.source rsp
);
	import aps_pkg::*;

	logic     push;
	aps_job_t push_job;
	logic     q_full;
	logic     pop;
	logic     head_valid;
	aps_job_t head_job;

	aps_front #(
		.WORDS_PER_SECTOR(WORDS_PER_SECTOR)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.q_full   (q_full),
		.push     (push),
		.push_job (push_job)
	);

	aps_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_job   (push_job),
		.full       (q_full),
		.pop        (pop),
		.head_valid (head_valid),
		.head_job   (head_job)
	);

	aps_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head_job   (head_job),
		.pop        (pop),
		.rsp        (rsp)
	);

endmodule

/* rtl/core/aps_checker.sv */
// Port-level checks on the result channel of the sequencer, bound to the top level.
`timescale 1ns / 1ps
module aps_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        rsp_valid,
	input logic        rsp_ready,
	input logic [1:0]  rsp_kind,
	input logic [15:0] rsp_port,
	input logic [15:0] rsp_value,
	input logic        rsp_last
);
	import aps_pkg::*;

	// A stalled result holds its contents.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_kind) && $stable(rsp_port)
			&& $stable(rsp_value) && $stable(rsp_last))
		else $error("stalled result changed");

	// Only data words can close a sector.
	a_last_data: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_last |-> rsp_kind == KIND_WORD_WR || rsp_kind == KIND_READ_DATA)
		else $error("last flag on a non-data result");

	// Byte writes and status reads carry nothing in the upper byte.
	a_byte_value: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp_kind == KIND_BYTE_WR || rsp_kind == KIND_STATUS_RD)
			|-> rsp_value[15:8] == 8'd0)
		else $error("upper byte set on a byte access");

	// Filtered read data never holds a zero byte.
	a_read_fill: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_kind == KIND_READ_DATA
			|-> rsp_value[7:0] != 8'd0 && rsp_value[15:8] != 8'd0)
		else $error("zero byte in filtered read data");

endmodule

bind ata_pio_sector_sequencer_core aps_checker u_aps_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.rsp_valid (rsp.valid),
	.rsp_ready (rsp.ready),
	.rsp_kind  (rsp.access_kind),
	.rsp_port  (rsp.port_address),
	.rsp_value (rsp.access_value),
	.rsp_last  (rsp.last)
);
